// ===== hdl/vcrle_pkg.sv =====
`default_nettype none

package vcrle_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [7:0] COEFS_MONO  = 8'd64;
  localparam logic [7:0] COEFS_COLOR = 8'd128;

  localparam logic       RST_COLOR_MODE    = 1'b0;
  localparam logic [9:0] RST_BLOCK_COLUMNS = 10'd40;
  localparam logic [9:0] RST_BLOCK_ROWS    = 10'd30;

  typedef enum logic [1:0] {
    CFG_COLOR_MODE    = 2'd0,
    CFG_BLOCK_COLUMNS = 2'd1,
    CFG_BLOCK_ROWS    = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_COUNT   = 3'd0,
    PH_COLUMN  = 3'd1,
    PH_ROW     = 3'd2,
    PH_RUN     = 3'd3,
    PH_LITERAL = 3'd4,
    PH_ERROR   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_ZEROS  = 2'd1,
    ST_STATUS = 2'd2
  } ctl_state_t;

  typedef enum logic [1:0] {
    LD_NONE   = 2'd0,
    LD_LIT    = 2'd1,
    LD_ZERO   = 2'd2,
    LD_STATUS = 2'd3
  } load_sel_t;

  typedef struct packed {
    logic      take;
    load_sel_t load_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic has_zeros;
    logic has_lit;
    logic zero_last;
    logic pend_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/video_coefficient_rle_decoder.sv =====
// Channel  Handshake              Payload
// in_      in_valid / in_ready    in_byte_value, in_packet_end
// out_     out_valid / out_ready  kind, value, position, column, row, done, error, last
// cfg_     cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// Header and literal bytes are taken one at a time; after a run byte with k zeros the
// zero-run sequencer emits one zero per cycle while out_ready allows, input held off.
// A final byte that also emits coefficients is followed by a separate status result.
// A single output register holds each result; a stalled out_ready stalls everything.
// Reset (rst_n low, synchronous) returns the parser to the group count byte and
// loads the default image size; no clearing pass is needed.
`default_nettype none

module video_coefficient_rle_decoder
  import vcrle_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_byte_value,
  input  wire logic                  in_packet_end,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_result_kind,
  output logic signed [7:0]          out_coef_value,
  output logic [6:0]                 out_coef_position,
  output logic [8:0]                 out_block_column,
  output logic [7:0]                 out_block_row,
  output logic                       out_block_done,
  output logic                       out_packet_error,
  output logic                       out_last_of_run
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  vcrle_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_packet_end (in_packet_end),
    .in_ready      (in_ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  vcrle_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_byte_value     (in_byte_value),
    .in_packet_end     (in_packet_end),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_coef_value    (out_coef_value),
    .out_coef_position (out_coef_position),
    .out_block_column  (out_block_column),
    .out_block_row     (out_block_row),
    .out_block_done    (out_block_done),
    .out_packet_error  (out_packet_error),
    .out_last_of_run   (out_last_of_run)
  );

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind |-> out_last_of_run)
    else $error("status result without last_of_run");

  a_coef_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_kind |-> !out_packet_error && !out_coef_position[6] ||
      out_valid && !out_result_kind && !out_packet_error)
    else $error("coefficient result carries packet_error");

  a_zero_run_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && stat.has_zeros |=> !in_ready)
    else $error("input taken while a zero run is pending");

  a_take_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && cmd.load_sel != LD_NONE |=> out_valid)
    else $error("result loaded on a transfer but not presented");

endmodule

`default_nettype wire

// ===== hdl/vcrle_ctrl.sv =====
`default_nettype none

module vcrle_ctrl
  import vcrle_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_packet_end,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.take     = 1'b0;
    cmd.load_sel = LD_NONE;
    case (state_r)
      ST_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.take = 1'b1;
          if (stat.has_zeros) begin
            state_nxt = ST_ZEROS;
          end else if (stat.has_lit) begin
            cmd.load_sel = LD_LIT;
            if (in_packet_end) begin
              state_nxt = ST_STATUS;
            end
          end else if (in_packet_end) begin
            cmd.load_sel = LD_STATUS;
          end
        end
      end
      ST_ZEROS: begin
        // one zero coefficient per free output slot
        if (stat.out_free) begin
          cmd.load_sel = LD_ZERO;
          if (stat.zero_last) begin
            state_nxt = stat.pend_last ? ST_STATUS : ST_IDLE;
          end
        end
      end
      ST_STATUS: begin
        if (stat.out_free) begin
          cmd.load_sel = LD_STATUS;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/vcrle_dp.sv =====
`default_nettype none

module vcrle_dp
  import vcrle_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [7:0]            in_byte_value,
  input  wire logic                  in_packet_end,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_result_kind,
  output logic signed [7:0]          out_coef_value,
  output logic [6:0]                 out_coef_position,
  output logic [8:0]                 out_block_column,
  output logic [7:0]                 out_block_row,
  output logic                       out_block_done,
  output logic                       out_packet_error,
  output logic                       out_last_of_run
);

  // configuration
  logic       color_r;
  logic [9:0] bcols_r;
  logic [9:0] brows_r;

  // parse state
  phase_t     phase_r, phase_nxt;
  logic [7:0] blocks_left_r, blocks_left_nxt;
  logic [8:0] column_r, column_nxt;
  logic [7:0] row_r, row_nxt;
  logic [7:0] coef_r, coef_nxt;
  logic [1:0] lit_left_r, lit_left_nxt;
  logic [5:0] trail_r, trail_nxt;
  logic       error_r, error_nxt;

  // pending zero run and status
  logic [6:0] zpos_r;
  logic [5:0] zleft_r;
  logic       zdone_r;
  logic [8:0] zcol_r;
  logic [7:0] zrow_r;
  logic       pend_last_r;
  logic       status_err_r;

  // output register
  logic        out_valid_r;
  logic        kind_r;
  logic [7:0]  value_r;
  logic [6:0]  pos_r;
  logic [8:0]  col_r;
  logic [7:0]  brow_r;
  logic        done_r;
  logic        err_r;
  logic        last_r;

  // decode
  logic [7:0] lim;
  logic [1:0] run_j;
  logic [5:0] run_k;
  logic [8:0] run_sum;
  logic [9:0] hdr_span;
  logic       hdr_bad;
  logic [7:0] lit_pos;
  logic [7:0] blocks_dec;
  logic [7:0] zpos_new;
  logic       zdone_new;
  logic       lit_done;
  logic       has_zeros;
  logic       has_lit;
  logic       err_now;
  logic       out_free;

  assign lim        = color_r ? COEFS_COLOR : COEFS_MONO;
  assign run_j      = in_byte_value[7:6];
  assign run_k      = in_byte_value[5:0];
  assign run_sum    = {1'b0, coef_r} + {7'd0, run_j} + {3'd0, run_k};
  assign hdr_span   = {1'b0, column_r} + {2'd0, blocks_left_r};
  assign hdr_bad    = (hdr_span > bcols_r) || ({2'd0, in_byte_value} >= brows_r);
  assign lit_pos    = coef_r - {2'd0, trail_r} - {6'd0, lit_left_r};
  assign blocks_dec = blocks_left_r - 8'd1;
  assign zpos_new   = coef_r + {6'd0, run_j};
  assign zdone_new  = (run_j == 2'd0) && (run_sum == {1'b0, lim});
  assign lit_done   = (lit_left_r == 2'd1) && (coef_r == lim);
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    phase_nxt       = phase_r;
    blocks_left_nxt = blocks_left_r;
    column_nxt      = column_r;
    row_nxt         = row_r;
    coef_nxt        = coef_r;
    lit_left_nxt    = lit_left_r;
    trail_nxt       = trail_r;
    error_nxt       = error_r;
    has_zeros       = 1'b0;
    has_lit         = 1'b0;
    case (phase_r)
      PH_COUNT: begin
        blocks_left_nxt = in_byte_value;
        phase_nxt       = PH_COLUMN;
      end
      PH_COLUMN: begin
        column_nxt = {1'b0, in_byte_value};
        phase_nxt  = PH_ROW;
      end
      PH_ROW: begin
        row_nxt = in_byte_value;
        if (hdr_bad) begin
          phase_nxt = PH_ERROR;
          error_nxt = 1'b1;
        end else begin
          coef_nxt  = 8'd0;
          phase_nxt = (blocks_left_r == 8'd0) ? PH_COUNT : PH_RUN;
        end
      end
      PH_RUN: begin
        if (run_sum > {1'b0, lim}) begin
          phase_nxt = PH_ERROR;
          error_nxt = 1'b1;
        end else begin
          has_zeros = (run_k != 6'd0);
          coef_nxt  = run_sum[7:0];
          if (run_j != 2'd0) begin
            lit_left_nxt = run_j;
            trail_nxt    = run_k;
            phase_nxt    = PH_LITERAL;
          end else if (run_sum == {1'b0, lim}) begin
            blocks_left_nxt = blocks_dec;
            column_nxt      = column_r + 9'd1;
            coef_nxt        = 8'd0;
            phase_nxt       = (blocks_dec == 8'd0) ? PH_COUNT : PH_RUN;
          end
        end
      end
      PH_LITERAL: begin
        has_lit      = 1'b1;
        lit_left_nxt = lit_left_r - 2'd1;
        if (lit_left_r == 2'd1) begin
          trail_nxt = 6'd0;
          if (coef_r == lim) begin
            blocks_left_nxt = blocks_dec;
            column_nxt      = column_r + 9'd1;
            coef_nxt        = 8'd0;
            phase_nxt       = (blocks_dec == 8'd0) ? PH_COUNT : PH_RUN;
          end else begin
            phase_nxt = PH_RUN;
          end
        end
      end
      default: begin
        // error: ignore the rest of the packet
      end
    endcase
    err_now = error_nxt || (phase_nxt != PH_COUNT);
    if (in_packet_end) begin
      phase_nxt       = PH_COUNT;
      error_nxt       = 1'b0;
      blocks_left_nxt = 8'd0;
      coef_nxt        = 8'd0;
      lit_left_nxt    = 2'd0;
      trail_nxt       = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r       <= RST_COLOR_MODE;
      bcols_r       <= RST_BLOCK_COLUMNS;
      brows_r       <= RST_BLOCK_ROWS;
      phase_r       <= PH_COUNT;
      blocks_left_r <= 8'd0;
      column_r      <= 9'd0;
      row_r         <= 8'd0;
      coef_r        <= 8'd0;
      lit_left_r    <= 2'd0;
      trail_r       <= 6'd0;
      error_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_COLOR_MODE:    color_r <= cfg_data[0];
          CFG_BLOCK_COLUMNS: bcols_r <= cfg_data;
          CFG_BLOCK_ROWS:    brows_r <= cfg_data;
          default: begin
            // unmapped index: drop the write
          end
        endcase
      end
      if (cmd.take) begin
        phase_r       <= phase_nxt;
        blocks_left_r <= blocks_left_nxt;
        column_r      <= column_nxt;
        row_r         <= row_nxt;
        coef_r        <= coef_nxt;
        lit_left_r    <= lit_left_nxt;
        trail_r       <= trail_nxt;
        error_r       <= error_nxt;
      end
      if (cmd.load_sel != LD_NONE) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      // capture the zero run with the block it belongs to
      zpos_r       <= zpos_new[6:0];
      zleft_r      <= run_k;
      zdone_r      <= zdone_new;
      zcol_r       <= column_r;
      zrow_r       <= row_r;
      pend_last_r  <= in_packet_end;
      status_err_r <= err_now;
    end else if (cmd.load_sel == LD_ZERO) begin
      zpos_r  <= zpos_r + 7'd1;
      zleft_r <= zleft_r - 6'd1;
    end
    case (cmd.load_sel)
      LD_LIT: begin
        kind_r  <= 1'b0;
        value_r <= in_byte_value;
        pos_r   <= lit_pos[6:0];
        col_r   <= column_r;
        brow_r  <= row_r;
        done_r  <= lit_done;
        err_r   <= 1'b0;
        last_r  <= !in_packet_end;
      end
      LD_ZERO: begin
        kind_r  <= 1'b0;
        value_r <= 8'd0;
        pos_r   <= zpos_r;
        col_r   <= zcol_r;
        brow_r  <= zrow_r;
        done_r  <= zdone_r && (zleft_r == 6'd1);
        err_r   <= 1'b0;
        last_r  <= (zleft_r == 6'd1) && !pend_last_r;
      end
      LD_STATUS: begin
        kind_r  <= 1'b1;
        value_r <= 8'd0;
        pos_r   <= 7'd0;
        col_r   <= 9'd0;
        brow_r  <= 8'd0;
        done_r  <= 1'b0;
        err_r   <= cmd.take ? err_now : status_err_r;
        last_r  <= 1'b1;
      end
      default: begin
        // hold
      end
    endcase
  end

  assign stat.out_free  = out_free;
  assign stat.has_zeros = has_zeros;
  assign stat.has_lit   = has_lit;
  assign stat.zero_last = (zleft_r == 6'd1);
  assign stat.pend_last = pend_last_r;

  assign out_valid         = out_valid_r;
  assign out_result_kind   = kind_r;
  assign out_coef_value    = $signed(value_r);
  assign out_coef_position = pos_r;
  assign out_block_column  = col_r;
  assign out_block_row     = brow_r;
  assign out_block_done    = done_r;
  assign out_packet_error  = err_r;
  assign out_last_of_run   = last_r;

endmodule

`default_nettype wire

// ===== tb/rle_coef_checker.sv =====
`timescale 1ns / 1ps

module rle_coef_checker
  import vcrle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_byte_value,
  input  logic                  in_packet_end,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_result_kind,
  input  logic signed [7:0]     out_coef_value,
  input  logic [6:0]            out_coef_position,
  input  logic [8:0]            out_block_column,
  input  logic [7:0]            out_block_row,
  input  logic                  out_block_done,
  input  logic                  out_packet_error,
  input  logic                  out_last_of_run,
  output int                    error_count,
  output int                    pending
);

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic [6:0] pos;
    logic [8:0] col;
    logic [7:0] row;
    logic       done;
    logic       err;
    logic       last;
  } coef_result_t;

  coef_result_t coef_expect_q[$];

  // Image geometry as last written through the cfg port
  logic       color_mode;
  logic [9:0] block_columns;
  logic [9:0] block_rows;

  // Parser state
  phase_t     phase;
  logic [7:0] blocks_left;
  logic [8:0] column;
  logic [7:0] row;
  logic [7:0] claimed;
  logic [1:0] lits_left;
  logic [5:0] tail_zeros;
  logic       error_seen;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [8:0] got,
                             input logic [8:0] want);
    if (got !== want) report_mismatch($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
  endtask

  function automatic coef_result_t make_result(input logic kind, input logic [7:0] value,
                                               input int pos, input logic done,
                                               input logic err);
    coef_result_t r;
    r.kind  = kind;
    r.value = value;
    r.pos   = pos[6:0];
    r.col   = kind ? 9'd0 : column;
    r.row   = kind ? 8'd0 : row;
    r.done  = done;
    r.err   = err;
    r.last  = 1'b0;
    return r;
  endfunction

  task automatic close_block();
    blocks_left = blocks_left - 8'd1;
    column      = column + 9'd1;
    claimed     = '0;
    phase       = (blocks_left == 8'd0) ? PH_COUNT : PH_RUN;
  endtask

  // Advance the parser by one byte and queue every result it produces
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    coef_result_t step_q[$];
    coef_result_t r;
    int lim;
    int lits;
    int zeros;
    int pos;
    int i;
    lim   = color_mode ? int'(COEFS_COLOR) : int'(COEFS_MONO);
    lits  = int'(b[7:6]);
    zeros = int'(b[5:0]);
    case (phase)
      PH_COUNT: begin
        blocks_left = b;
        phase       = PH_COLUMN;
      end
      PH_COLUMN: begin
        column = {1'b0, b};
        phase  = PH_ROW;
      end
      PH_ROW: begin
        row = b;
        if (int'(column) + int'(blocks_left) > int'(block_columns) || row >= block_rows) begin
          phase      = PH_ERROR;
          error_seen = 1'b1;
        end else begin
          claimed = '0;
          phase   = (blocks_left == 8'd0) ? PH_COUNT : PH_RUN;
        end
      end
      PH_RUN: begin
        if (int'(claimed) + lits + zeros > lim) begin
          phase      = PH_ERROR;
          error_seen = 1'b1;
        end else begin
          // zeros go out now, at their slots behind the literals still to come
          for (i = 0; i < zeros; i++) begin
            step_q.push_back(make_result(1'b0, 8'h00, int'(claimed) + lits + i,
                                         lits == 0 && i == zeros - 1 &&
                                         int'(claimed) + zeros == lim, 1'b0));
          end
          claimed = 8'(int'(claimed) + lits + zeros);
          if (lits > 0) begin
            lits_left  = b[7:6];
            tail_zeros = b[5:0];
            phase      = PH_LITERAL;
          end else if (int'(claimed) == lim) begin
            close_block();
          end
        end
      end
      PH_LITERAL: begin
        pos = int'(claimed) - int'(tail_zeros) - int'(lits_left);
        step_q.push_back(make_result(1'b0, b, pos,
                                     lits_left == 2'd1 && int'(claimed) == lim, 1'b0));
        lits_left = lits_left - 2'd1;
        if (lits_left == 2'd0) begin
          tail_zeros = '0;
          if (int'(claimed) == lim) close_block();
          else phase = PH_RUN;
        end
      end
      default: ;
    endcase

    if (fin) begin
      step_q.push_back(make_result(1'b1, 8'h00, 0, 1'b0,
                                   error_seen || phase != PH_COUNT));
      phase       = PH_COUNT;
      error_seen  = 1'b0;
      blocks_left = '0;
      claimed     = '0;
      lits_left   = '0;
      tail_zeros  = '0;
    end

    foreach (step_q[k]) begin
      r      = step_q[k];
      r.last = (k == step_q.size() - 1);
      coef_expect_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin : monitor
    coef_result_t want;
    if (!rst_n) begin
      color_mode    = RST_COLOR_MODE;
      block_columns = RST_BLOCK_COLUMNS;
      block_rows    = RST_BLOCK_ROWS;
      phase         = PH_COUNT;
      blocks_left   = '0;
      column        = '0;
      row           = '0;
      claimed       = '0;
      lits_left     = '0;
      tail_zeros    = '0;
      error_seen    = 1'b0;
      coef_expect_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (coef_expect_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = coef_expect_q.pop_front();
          check_field("result_kind", out_result_kind, want.kind);
          check_field("coef_value", {1'b0, out_coef_value}, {1'b0, want.value});
          check_field("coef_position", out_coef_position, want.pos);
          check_field("block_column", out_block_column, want.col);
          check_field("block_row", out_block_row, want.row);
          check_field("block_done", out_block_done, want.done);
          check_field("packet_error", out_packet_error, want.err);
          check_field("last_of_run", out_last_of_run, want.last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_COLOR_MODE:    color_mode    = cfg_data[0];
          CFG_BLOCK_COLUMNS: block_columns = cfg_data;
          CFG_BLOCK_ROWS:    block_rows    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) decode_byte(in_byte_value, in_packet_end);
    end
    pending = coef_expect_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import vcrle_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_byte_value;
  logic                  in_packet_end;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_result_kind;
  logic signed [7:0]     out_coef_value;
  logic [6:0]            out_coef_position;
  logic [8:0]            out_block_column;
  logic [7:0]            out_block_row;
  logic                  out_block_done;
  logic                  out_packet_error;
  logic                  out_last_of_run;

  int error_count;
  int pending;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;
  int bytes_sent;

  // Geometry currently programmed, used to shape legal packets
  logic       cur_color;
  logic [9:0] cur_cols;
  logic [9:0] cur_rows;

  video_coefficient_rle_decoder DUT (.*);

  rle_coef_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_byte_value = b;
    in_packet_end = fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [7:0] pkt[$]);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // Hold off the input until every queued result has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [9:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic color, input logic [9:0] cols, input logic [9:0] rows);
    wait_drained();
    write_reg(CFG_COLOR_MODE, {9'd0, color});
    write_reg(CFG_BLOCK_COLUMNS, cols);
    write_reg(CFG_BLOCK_ROWS, rows);
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_color = color;
    cur_cols  = cols;
    cur_rows  = rows;
  endtask

  // Mostly legal packets for the current geometry; some truncated or corrupted
  task automatic build_packet(output logic [7:0] pkt[$]);
    int lim;
    int nblk;
    int col_max;
    int row_max;
    int left;
    int lits;
    int zeros;
    int zmax;
    int cut;
    pkt.delete();
    lim = cur_color ? int'(COEFS_COLOR) : int'(COEFS_MONO);
    repeat ($urandom_range(1, 3)) begin
      nblk = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
      if (nblk > int'(cur_cols)) nblk = int'(cur_cols);
      col_max = int'(cur_cols) - nblk;
      if (col_max > 255) col_max = 255;
      row_max = (cur_rows == 10'd0) ? 0 : int'(cur_rows) - 1;
      if (row_max > 255) row_max = 255;
      pkt.push_back(8'(nblk));
      pkt.push_back(8'($urandom_range(0, col_max)));
      pkt.push_back(8'($urandom_range(0, row_max)));
      repeat (nblk) begin
        left = lim;
        while (left > 0) begin
          lits = $urandom_range(0, (left < 3) ? left : 3);
          zmax = left - lits;
          if (zmax > 63) zmax = 63;
          zeros = ($urandom_range(0, 3) == 0) ? zmax : $urandom_range(0, (zmax < 12) ? zmax : 12);
          pkt.push_back({lits[1:0], zeros[5:0]});
          repeat (lits) pkt.push_back(8'($urandom));
          left -= lits + zeros;
        end
      end
    end
    case ($urandom_range(0, 9))
      0: begin
        cut = $urandom_range(1, pkt.size());
        pkt = pkt[0:cut-1];
      end
      1: pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
      2: begin
        pkt.delete();
        repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
      end
      default: ;
    endcase
  endtask

  task automatic random_traffic(input int nbytes);
    logic [7:0] pkt[$];
    int target;
    target = bytes_sent + nbytes;
    while (bytes_sent < target) begin
      build_packet(pkt);
      send_packet(pkt);
    end
  endtask

  initial begin
    logic [7:0] pkt[$];
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_COLOR_MODE;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_byte_value = '0;
    in_packet_end = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    configure(1'b0, 10'd40, 10'd30);
    // one full block: empty run byte, extreme literals, zeros closing the block
    pkt = '{8'h01, 8'h00, 8'h00, 8'h00, 8'hFC, 8'h80, 8'h7F, 8'h00, 8'h01};
    send_packet(pkt);
    // block closed by its literal, then a header past the right edge
    pkt = '{8'h01, 8'h27, 8'h1D, 8'h7F, 8'hAA, 8'h02, 8'h27, 8'h1D};
    send_packet(pkt);
    // empty group, then an overflowing run byte and a byte that must be dropped
    pkt = '{8'h00, 8'h28, 8'h1D, 8'h01, 8'h00, 8'h00, 8'hFF, 8'h55};
    send_packet(pkt);
    // packet cut while a literal is still owed
    pkt = '{8'h01, 8'h00, 8'h00, 8'h40};
    send_packet(pkt);
    random_traffic(80);

    configure(1'b1, 10'd1023, 10'd1023);
    idle_pct = 55;
    random_traffic(110);

    configure(1'b0, 10'd0, 10'd0);
    idle_pct  = 0;
    stall_pct = 55;
    random_traffic(30);

    configure(1'b1, 10'd17, 10'd5);
    random_traffic(100);

    configure(1'b0, 10'd300, 10'd256);
    idle_pct  = 10;
    stall_pct = 10;
    random_traffic(100);

    configure(1'b1, 10'd40, 10'd30);
    idle_pct  = 0;
    stall_pct = 0;
    random_traffic(80);

    wait_drained();
    if (error_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
